/* rtl/tdpb_pkg.sv */
// Shared types and constants for the tail-drop packet buffer timer.
// No dependencies; used by every module of the block.
`default_nettype none

package tdpb_pkg;

    // Field widths fixed by the interface
    localparam int TIME_W = 32;
    localparam int PROC_W = 16;
    localparam int SIZE_W = 7;

    // Default ring depth and reset value of the buffer size register
    localparam int DEPTH_DEFAULT = 64;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND
    } t_state;

    // Shared arithmetic unit operations
    typedef enum logic {
        ALU_CMP,
        ALU_ADD_SAT
    } t_alu_op;

endpackage

`default_nettype wire

/* rtl/tdpb_alu.sv */
// Shared 33-bit add/subtract unit: compare (a < b) or saturating add.
// Depends on tdpb_pkg.
`default_nettype none

module tdpb_alu (
    input  wire tdpb_pkg::t_alu_op      i_op,
    input  wire [tdpb_pkg::TIME_W-1:0]  i_a,
    input  wire [tdpb_pkg::TIME_W-1:0]  i_b,
    output logic [tdpb_pkg::TIME_W-1:0] o_sum,
    output logic                        o_lt
);

    logic [tdpb_pkg::TIME_W:0] w_x;
    logic [tdpb_pkg::TIME_W:0] w_y;
    logic [tdpb_pkg::TIME_W:0] w_s;
    logic                      w_cin;

    // One adder: a - b for compare, a + b for the finish time
    always_comb begin
        w_x   = {1'b0, i_a};
        w_y   = (i_op == tdpb_pkg::ALU_CMP) ? ~{1'b0, i_b} : {1'b0, i_b};
        w_cin = (i_op == tdpb_pkg::ALU_CMP);
        w_s   = w_x + w_y + {{tdpb_pkg::TIME_W{1'b0}}, w_cin};
    end

    // Borrow flags a < b; carry out saturates the sum
    always_comb begin
        o_lt  = w_s[tdpb_pkg::TIME_W];
        o_sum = (i_op == tdpb_pkg::ALU_ADD_SAT && w_s[tdpb_pkg::TIME_W])
              ? {tdpb_pkg::TIME_W{1'b1}} : w_s[tdpb_pkg::TIME_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/tdpb_ring.sv */
// Ring storage of queued finish times: one write port, one registered read port.
// Depends on tdpb_pkg.
`default_nettype none

module tdpb_ring #(
    parameter int DEPTH = tdpb_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                         i_clk,
    input  wire                         i_wr_en,
    input  wire [IDX_W-1:0]             i_wr_addr,
    input  wire [tdpb_pkg::TIME_W-1:0]  i_wr_data,
    input  wire [IDX_W-1:0]             i_rd_addr,
    output logic [tdpb_pkg::TIME_W-1:0] o_rd_data
);

    logic [tdpb_pkg::TIME_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/tail_drop_packet_buffer_timer_core.sv */
// Tail-drop packet buffer timer: sequencer, queue pointers and result register.
// Depends on tdpb_pkg, tdpb_alu and tdpb_ring.
//
// One packet is in flight at a time: busy is high from the cycle after start
// is taken until the result strobe. A queued packet holds busy through the
// scan state, which pops expired finish times from the queue front, and the
// append state, and its result strobe follows in the next cycle; a dropped
// packet skips the append state. The scan reads one ring entry per cycle
// through the single read port and checks it on the shared adder, which also
// forms the finish time. The result is driven for one cycle with o_strobe and
// cannot be held off, and a new start is taken in that same cycle, so a new
// packet is taken only once the previous one has its result. The buffer size
// register may be written at any time the block is idle; o_cfg_ready is
// always high.
`default_nettype none

module tail_drop_packet_buffer_timer_core #(
    parameter int DEPTH = tdpb_pkg::DEPTH_DEFAULT
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // Command channel
    input  wire                         start,
    output logic                        busy,
    input  wire [tdpb_pkg::TIME_W-1:0]  i_arrival_time,
    input  wire [tdpb_pkg::PROC_W-1:0]  i_process_time,
    // Result channel
    output logic                        o_strobe,
    output logic                        o_dropped,
    output logic [tdpb_pkg::TIME_W-1:0] o_service_start,
    // Configuration channel
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [tdpb_pkg::SIZE_W-1:0]  i_cfg_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > tdpb_pkg::SIZE_W) ? CNT_W : tdpb_pkg::SIZE_W;

    tdpb_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0]            r_head, n_head;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [tdpb_pkg::SIZE_W-1:0] r_buffer_size;
    logic [tdpb_pkg::TIME_W-1:0] r_arrival;
    logic [tdpb_pkg::PROC_W-1:0] r_proc;
    logic [tdpb_pkg::TIME_W-1:0] r_start, n_start;
    logic [tdpb_pkg::TIME_W-1:0] r_last, n_last;
    logic                        r_strobe, n_strobe;
    logic                        r_dropped, n_dropped;
    logic [tdpb_pkg::TIME_W-1:0] r_out_time, n_out_time;

    logic                        w_accept;
    logic [IDX_W-1:0]            w_head_inc;
    logic [SUM_W-1:0]            w_tail_sum;
    logic [IDX_W-1:0]            w_tail;
    logic                        w_pop;
    logic                        w_full;
    logic [IDX_W-1:0]            w_rd_addr;
    logic                        w_wr_en;
    logic [tdpb_pkg::TIME_W-1:0] w_rd_data;
    tdpb_pkg::t_alu_op           w_alu_op;
    logic [tdpb_pkg::TIME_W-1:0] w_alu_a;
    logic [tdpb_pkg::TIME_W-1:0] w_alu_b;
    logic [tdpb_pkg::TIME_W-1:0] w_alu_sum;
    logic                        w_alu_lt;

    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_dropped   = r_dropped;
    assign o_service_start = r_out_time;

    // Ring pointer arithmetic
    always_comb begin
        w_head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
        w_tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (w_tail_sum >= SUM_W'(DEPTH)) begin
            w_tail = IDX_W'(w_tail_sum - SUM_W'(DEPTH));
        end else begin
            w_tail = IDX_W'(w_tail_sum);
        end
    end

    // Shared unit operands: compare head entry in scan, add in append
    always_comb begin
        if (r_state == tdpb_pkg::S_APPEND) begin
            w_alu_op = tdpb_pkg::ALU_ADD_SAT;
            w_alu_a  = r_start;
            w_alu_b  = {{(tdpb_pkg::TIME_W - tdpb_pkg::PROC_W){1'b0}}, r_proc};
        end else begin
            w_alu_op = tdpb_pkg::ALU_CMP;
            w_alu_a  = r_arrival;
            w_alu_b  = w_rd_data;
        end
    end

    tdpb_alu u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_sum (w_alu_sum),
        .o_lt  (w_alu_lt)
    );

    // Head entry expired when it is at or before the arrival
    assign w_pop  = (r_count != '0) && !w_alu_lt;
    assign w_full = (CMP_W'(r_count) >= CMP_W'(r_buffer_size))
                 || (r_count == CNT_W'(DEPTH));

    assign w_rd_addr = (r_state == tdpb_pkg::S_SCAN && w_pop) ? w_head_inc : r_head;
    assign w_wr_en   = (r_state == tdpb_pkg::S_APPEND);

    tdpb_ring #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_tail),
        .i_wr_data (w_alu_sum),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdpb_pkg::S_IDLE: begin
                if (w_accept) n_state = tdpb_pkg::S_SCAN;
            end
            tdpb_pkg::S_SCAN: begin
                if (!w_pop) n_state = w_full ? tdpb_pkg::S_IDLE : tdpb_pkg::S_APPEND;
            end
            tdpb_pkg::S_APPEND: begin
                n_state = tdpb_pkg::S_IDLE;
            end
            default: n_state = tdpb_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: pointer updates and result
    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_start    = r_start;
        n_last     = r_last;
        n_strobe   = 1'b0;
        n_dropped  = r_dropped;
        n_out_time = r_out_time;
        busy       = (r_state != tdpb_pkg::S_IDLE);
        unique case (r_state)
            tdpb_pkg::S_IDLE: ;
            tdpb_pkg::S_SCAN: begin
                if (w_pop) begin
                    n_head  = w_head_inc;
                    n_count = r_count - CNT_W'(1);
                end else if (w_full) begin
                    n_strobe   = 1'b1;
                    n_dropped  = 1'b1;
                    n_out_time = '0;
                end else begin
                    n_start = (r_count == '0) ? r_arrival : r_last;
                end
            end
            tdpb_pkg::S_APPEND: begin
                n_count    = r_count + CNT_W'(1);
                n_last     = w_alu_sum;
                n_strobe   = 1'b1;
                n_dropped  = 1'b0;
                n_out_time = r_start;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tdpb_pkg::S_IDLE;
            r_head        <= '0;
            r_count       <= '0;
            r_buffer_size <= tdpb_pkg::SIZE_RESET;
            r_strobe      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_buffer_size <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_arrival <= i_arrival_time;
            r_proc    <= i_process_time;
        end
        r_start    <= n_start;
        r_last     <= n_last;
        r_dropped  <= n_dropped;
        r_out_time <= n_out_time;
    end

endmodule

`default_nettype wire
